// ===== rtl/swps_pkg.sv =====
// Shared types, constants and the arctangent table of the world pose solver.
package swps_pkg;

	localparam int MAX_BONES_DEF = 64;

	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOT_POS_X   = 3'd0,
		REG_ROOT_POS_Y   = 3'd1,
		REG_ROOT_ANGLE   = 3'd2,
		REG_ROOT_SCALE_X = 3'd3,
		REG_ROOT_SCALE_Y = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROT,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              load;
		logic              rot;
		logic              mul;
		logic              finish;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	// arctan(2^-i) in units of 2^18 per turn
	function automatic logic signed [19:0] atan_units(input logic [STEP_W-1:0] i);
		logic signed [19:0] r;
		unique case (i)
			5'd0:    r = 20'sd32768;
			5'd1:    r = 20'sd19344;
			5'd2:    r = 20'sd10221;
			5'd3:    r = 20'sd5188;
			5'd4:    r = 20'sd2604;
			5'd5:    r = 20'sd1303;
			5'd6:    r = 20'sd652;
			5'd7:    r = 20'sd326;
			5'd8:    r = 20'sd163;
			5'd9:    r = 20'sd81;
			5'd10:   r = 20'sd41;
			5'd11:   r = 20'sd20;
			5'd12:   r = 20'sd10;
			5'd13:   r = 20'sd5;
			5'd14:   r = 20'sd3;
			5'd15:   r = 20'sd1;
			5'd16:   r = 20'sd1;
			default: r = 20'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/swps_ifs.sv =====
// Channel interfaces: bone request, pose result and configuration write.
interface swps_bone_if;
	logic               valid;
	logic               ready;
	logic [5:0]         bone_index;
	logic signed [6:0]  parent_index;
	logic signed [31:0] local_x;
	logic signed [31:0] local_y;
	logic [15:0]        local_angle;
	logic signed [15:0] local_scale_x;
	logic signed [15:0] local_scale_y;

	modport source (output valid, bone_index, parent_index, local_x, local_y, local_angle,
		local_scale_x, local_scale_y, input ready);
	modport sink (input valid, bone_index, parent_index, local_x, local_y, local_angle,
		local_scale_x, local_scale_y, output ready);
endinterface

interface swps_pose_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_bone;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic [15:0]        world_angle;
	logic signed [15:0] world_scale_x;
	logic signed [15:0] world_scale_y;
	logic               order_error;

	modport source (output valid, out_bone, world_x, world_y, world_angle, world_scale_x,
		world_scale_y, order_error, input ready);
	modport sink (input valid, out_bone, world_x, world_y, world_angle, world_scale_x,
		world_scale_y, order_error, output ready);
endinterface

interface swps_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [swps_pkg::CFG_IDX_W-1:0]    index;
	logic [swps_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/swps_ctrl.sv =====
// Sequencer: accept, parent load, CORDIC iterations, shared multiply, write back.
module swps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  swps_pkg::sts_t sts,
	output swps_pkg::cmd_t cmd
);
	import swps_pkg::*;

	localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(4);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d)
				step_q <= '0;
			else if (state_q == ST_ROT || state_q == ST_MUL)
				step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ROT;
			ST_ROT:  if (step_q == ROT_LAST) state_d = ST_MUL;
			ST_MUL:  if (step_q == MUL_LAST) state_d = ST_DONE;
			ST_DONE: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.step    = step_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOAD: cmd.load = 1'b1;
			ST_ROT:  cmd.rot = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_DONE: cmd.finish = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/swps_dp.sv =====
// Datapath: root registers, bone store, CORDIC unit, shared multiplier, result register.
module swps_dp #(
	parameter int MAX_BONES = swps_pkg::MAX_BONES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  swps_pkg::cmd_t cmd,
	output swps_pkg::sts_t sts,
	swps_bone_if.sink      bone,
	swps_pose_if.source    pose,
	swps_cfg_if.sink       cfg
);
	import swps_pkg::*;

	localparam int AW = $clog2(MAX_BONES);
	localparam int IW = (AW > 6) ? AW : 6;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        angle;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
	} xform_t;

	// root registers
	logic signed [31:0] root_x_q, root_y_q;
	logic [15:0]        root_angle_q;
	logic signed [15:0] root_sx_q, root_sy_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_x_q     <= '0;
			root_y_q     <= '0;
			root_angle_q <= '0;
			root_sx_q    <= 16'sd256;
			root_sy_q    <= 16'sd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROOT_POS_X:   root_x_q <= cfg.data;
				REG_ROOT_POS_Y:   root_y_q <= cfg.data;
				REG_ROOT_ANGLE:   root_angle_q <= cfg.data[15:0];
				REG_ROOT_SCALE_X: root_sx_q <= cfg.data[15:0];
				REG_ROOT_SCALE_Y: root_sy_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// request capture and parent decode
	logic               par_nonneg, par_err, bone_ok;
	logic [IW-1:0]      par_wide, bone_wide;
	logic [5:0]         bone_q;
	logic signed [31:0] lx_q, ly_q;
	logic [15:0]        la_q;
	logic signed [15:0] lsx_q, lsy_q;
	logic               use_root_q, err_q, store_ok_q;
	logic [AW-1:0]      wr_addr_q;

	assign par_nonneg = !bone.parent_index[6];
	assign par_err = par_nonneg && ((bone.parent_index[5:0] >= bone.bone_index)
		|| (32'(bone.parent_index[5:0]) >= 32'(MAX_BONES)));
	assign bone_ok = 32'(bone.bone_index) < 32'(MAX_BONES);
	assign par_wide = IW'(bone.parent_index[5:0]);
	assign bone_wide = IW'(bone.bone_index);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bone_q     <= bone.bone_index;
			lx_q       <= bone.local_x;
			ly_q       <= bone.local_y;
			la_q       <= bone.local_angle;
			lsx_q      <= bone.local_scale_x;
			lsy_q      <= bone.local_scale_y;
			use_root_q <= !par_nonneg || par_err;
			err_q      <= par_err;
			store_ok_q <= bone_ok;
			wr_addr_q  <= bone_wide[AW-1:0];
		end
	end

	// bone store
	xform_t mem [MAX_BONES];
	xform_t rd_q;
	xform_t wr_data;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			rd_q <= mem[par_wide[AW-1:0]];
		if (cmd.finish && store_ok_q)
			mem[wr_addr_q] <= wr_data;
	end

	// parent transform and CORDIC
	xform_t             par_q;
	logic               flip_q;
	logic signed [32:0] cx_q, cy_q;
	logic signed [19:0] z_q;
	logic [15:0]        sel_angle, red_angle;
	logic               sel_flip;
	logic signed [32:0] dx, dy;
	logic signed [19:0] da;

	assign sel_angle = use_root_q ? root_angle_q : rd_q.angle;
	assign sel_flip  = sel_angle[15] ^ sel_angle[14];
	assign red_angle = {sel_angle[15] ^ sel_flip, sel_angle[14:0]};
	assign dx = cy_q >>> cmd.step;
	assign dy = cx_q >>> cmd.step;
	assign da = atan_units(cmd.step);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (use_root_q)
				par_q <= '{root_x_q, root_y_q, root_angle_q, root_sx_q, root_sy_q};
			else
				par_q <= rd_q;
			flip_q <= sel_flip;
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			z_q    <= {{2{red_angle[15]}}, red_angle, 2'b00};
		end else if (cmd.rot) begin
			if (!z_q[19]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - da;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + da;
			end
		end
	end

	// scale products, taken while the rotation runs
	logic signed [31:0] sxp_q, syp_q;

	always_ff @(posedge clk) begin
		if (cmd.rot) begin
			sxp_q <= 32'(par_q.sx) * 32'(lsx_q);
			syp_q <= 32'(par_q.sy) * 32'(lsy_q);
		end
	end

	// shared multiplier: step k forms lx*c, ly*c, lx*s, ly*s; step k+1 accumulates it
	logic signed [32:0] cosv, sinv, b_op;
	logic signed [31:0] a_op;
	logic signed [64:0] prod_q;
	logic signed [65:0] accx_q, accy_q;
	logic [1:0]         msel, asel;

	assign cosv = flip_q ? -cx_q : cx_q;
	assign sinv = flip_q ? -cy_q : cy_q;
	assign msel = cmd.step[1:0];
	assign asel = 2'(cmd.step - 1'b1);
	assign a_op = msel[0] ? ly_q : lx_q;
	assign b_op = msel[1] ? sinv : cosv;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			if (cmd.step < STEP_W'(4))
				prod_q <= 65'(a_op) * 65'(b_op);
			if (cmd.step != '0) begin
				case (asel)
					2'd0:    accx_q <= 66'(prod_q);
					2'd1:    accy_q <= 66'(prod_q);
					2'd2:    accy_q <= accy_q + 66'(prod_q);
					default: accx_q <= accx_q - 66'(prod_q);
				endcase
			end
		end
	end

	// round, offset, saturate
	logic signed [65:0] rndx_full, rndy_full;
	logic signed [36:0] sumx, sumy;
	logic signed [32:0] sxr_full, syr_full;
	logic signed [24:0] sxr, syr;

	assign rndx_full = accx_q + (66'sd1 <<< 29);
	assign rndy_full = accy_q + (66'sd1 <<< 29);
	assign sumx = 37'(par_q.x) + 37'(rndx_full >>> 30);
	assign sumy = 37'(par_q.y) + 37'(rndy_full >>> 30);
	assign sxr_full = 33'(sxp_q) + 33'sd128;
	assign syr_full = 33'(syp_q) + 33'sd128;
	assign sxr = 25'(sxr_full >>> 8);
	assign syr = 25'(syr_full >>> 8);

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		if (v[36:31] == '0 || v[36:31] == '1)
			return v[31:0];
		return v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
		if (v[24:15] == '0 || v[24:15] == '1)
			return v[15:0];
		return v[24] ? 16'h8000 : 16'h7FFF;
	endfunction

	assign wr_data.x     = sat32(sumx);
	assign wr_data.y     = sat32(sumy);
	assign wr_data.angle = par_q.angle + la_q;
	assign wr_data.sx    = sat16(sxr);
	assign wr_data.sy    = sat16(syr);

	// result register
	logic   out_valid_q;
	xform_t out_q;
	logic   out_err_q;
	logic [5:0] out_bone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (pose.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q      <= wr_data;
			out_err_q  <= err_q;
			out_bone_q <= bone_q;
		end
	end

	assign sts.out_busy = out_valid_q && !pose.ready;

	assign pose.valid         = out_valid_q;
	assign pose.out_bone      = out_bone_q;
	assign pose.world_x       = out_q.x;
	assign pose.world_y       = out_q.y;
	assign pose.world_angle   = out_q.angle;
	assign pose.world_scale_x = out_q.sx;
	assign pose.world_scale_y = out_q.sy;
	assign pose.order_error   = out_err_q;

endmodule

// ===== rtl/skeleton_world_pose_solver.sv =====
// Top level of the 2D skeleton world pose solver.
//
//  channel | dir | contents
//  --------+-----+--------------------------------------------------------
//  bone    | in  | bone/parent index, local position, angle and scale
//  pose    | out | bone index, world position, angle, scale, order error
//  cfg     | in  | root transform register writes, always ready
//
// A request passes through accept, parent store read, 17 CORDIC iterations,
// the shared 32x33 multiplier for the position products, and write back.
// A new request is taken once the previous one has written its pose back.
// A result waits in the output register; only a second finished result stalls.
// Reset clears control state and loads root scale 1.0; the bone store is unset.
module skeleton_world_pose_solver #(
	parameter int MAX_BONES = swps_pkg::MAX_BONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	swps_bone_if.sink   bone,
	swps_pose_if.source pose,
	swps_cfg_if.sink    cfg
);
	import swps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	swps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bone.valid),
		.in_ready (bone.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swps_dp #(
		.MAX_BONES (MAX_BONES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.bone   (bone),
		.pose   (pose),
		.cfg    (cfg)
	);

endmodule
